[rtl/dit_pkg.sv]
// Shared types and constants for the dual interval timer block.
`default_nettype none
package dit_pkg;

  localparam int CNT_W  = 18;
  localparam int LATCH_W = 16;

  // request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register map
  localparam logic [3:0] ADDR_PORT_A  = 4'h0;
  localparam logic [3:0] ADDR_PORT_B  = 4'h1;
  localparam logic [3:0] ADDR_TA_LO   = 4'h4;
  localparam logic [3:0] ADDR_TA_HI   = 4'h5;
  localparam logic [3:0] ADDR_TB_LO   = 4'h6;
  localparam logic [3:0] ADDR_TB_HI   = 4'h7;
  localparam logic [3:0] ADDR_ICR     = 4'hD;
  localparam logic [3:0] ADDR_CRA     = 4'hE;
  localparam logic [3:0] ADDR_CRB     = 4'hF;

  // count source: processor clock
  localparam logic       SRC_A_CPU = 1'b0;
  localparam logic [1:0] SRC_B_CPU = 2'd0;

  localparam logic [7:0] PORT_RESET = 8'hff;

  typedef logic signed [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] elapsed_cycles;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_pulse;
    logic [15:0] video_bank_base;
  } res_t;

endpackage
`default_nettype wire

[rtl/dit_timer.sv]
// One interval timer: subtract elapsed cycles, detect expiry, reload.
`default_nettype none
module dit_timer (
  input  var dit_pkg::cnt_t                  count,
  input  var logic [dit_pkg::LATCH_W-1:0]    latch,
  input  var logic                           active,
  input  var logic                           int_en,
  input  var logic [7:0]                     dt,
  output dit_pkg::cnt_t                      count_nxt,
  output logic                               fired
);
  import dit_pkg::*;

  cnt_t diff;
  logic expired;

  always_comb begin
    diff      = count - signed'({{(CNT_W-8){1'b0}}, dt});
    expired   = diff[CNT_W-1] || (diff == '0);
    count_nxt = count;
    if (active) begin
      count_nxt = expired ? signed'({{(CNT_W-LATCH_W){1'b0}}, latch}) : diff;
    end
    fired = active && expired && int_en;
  end

endmodule
`default_nettype wire

[rtl/dit_core.sv]
// Register file, timer state and per-beat result logic.
`default_nettype none
module dit_core (
  input  var logic          clk,
  input  var logic          rst_n,
  input  var logic          fire,
  input  var dit_pkg::req_t req,
  output dit_pkg::res_t     res
);
  import dit_pkg::*;

  logic [7:0]         port_a_r, port_a_nxt;
  logic [7:0]         port_b_r, port_b_nxt;
  logic [LATCH_W-1:0] latch_a_r, latch_a_nxt;
  logic [LATCH_W-1:0] latch_b_r, latch_b_nxt;
  cnt_t               count_a_r, count_a_nxt;
  cnt_t               count_b_r, count_b_nxt;
  logic               run_a_r, run_a_nxt;
  logic               run_b_r, run_b_nxt;
  logic               src_a_r, src_a_nxt;
  logic [1:0]         src_b_r, src_b_nxt;
  logic               ien_a_r, ien_a_nxt;
  logic               ien_b_r, ien_b_nxt;
  logic               flag_a_r, flag_a_nxt;
  logic               flag_b_r, flag_b_nxt;

  logic is_tick;
  cnt_t tick_cnt_a, tick_cnt_b;
  logic fired_a, fired_b;

  assign is_tick = (req.req_type == REQ_TICK);

  dit_timer u_timer_a (
    .count     (count_a_r),
    .latch     (latch_a_r),
    .active    (is_tick && run_a_r && (src_a_r == SRC_A_CPU)),
    .int_en    (ien_a_r),
    .dt        (req.elapsed_cycles),
    .count_nxt (tick_cnt_a),
    .fired     (fired_a)
  );

  dit_timer u_timer_b (
    .count     (count_b_r),
    .latch     (latch_b_r),
    .active    (is_tick && run_b_r && (src_b_r == SRC_B_CPU)),
    .int_en    (ien_b_r),
    .dt        (req.elapsed_cycles),
    .count_nxt (tick_cnt_b),
    .fired     (fired_b)
  );

  always_comb begin
    logic [7:0] v;
    v           = req.write_data;
    port_a_nxt  = port_a_r;
    port_b_nxt  = port_b_r;
    latch_a_nxt = latch_a_r;
    latch_b_nxt = latch_b_r;
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    run_a_nxt   = run_a_r;
    run_b_nxt   = run_b_r;
    src_a_nxt   = src_a_r;
    src_b_nxt   = src_b_r;
    ien_a_nxt   = ien_a_r;
    ien_b_nxt   = ien_b_r;
    flag_a_nxt  = flag_a_r;
    flag_b_nxt  = flag_b_r;
    res         = '0;

    unique case (req.req_type)
      REQ_READ: begin
        unique case (req.reg_addr)
          ADDR_PORT_A: res.read_data = port_a_r;
          ADDR_PORT_B: res.read_data = port_b_r;
          ADDR_TA_LO:  res.read_data = count_a_r[7:0];
          ADDR_TA_HI:  res.read_data = count_a_r[15:8];
          ADDR_TB_LO:  res.read_data = count_b_r[7:0];
          ADDR_TB_HI:  res.read_data = count_b_r[15:8];
          ADDR_ICR:    res.read_data = (flag_a_r || flag_b_r) ?
                                       {1'b1, 5'b0, flag_b_r, flag_a_r} : 8'h00;
          default:     res.read_data = 8'h00;
        endcase
      end
      REQ_WRITE: begin
        unique case (req.reg_addr)
          ADDR_PORT_A: port_a_nxt = v;
          ADDR_PORT_B: port_b_nxt = v;
          ADDR_TA_LO:  latch_a_nxt = {latch_a_r[15:8], v};
          ADDR_TA_HI:  latch_a_nxt = {v, latch_a_r[7:0]};
          ADDR_TB_LO:  latch_b_nxt = {latch_b_r[15:8], v};
          ADDR_TB_HI:  latch_b_nxt = {v, latch_b_r[7:0]};
          ADDR_ICR: begin
            if (v[0]) ien_a_nxt = v[7];
            if (v[1]) ien_b_nxt = v[7];
          end
          ADDR_CRA: begin
            run_a_nxt = v[0];
            src_a_nxt = v[5];
            if (v[4]) count_a_nxt = signed'({{(CNT_W-LATCH_W){1'b0}}, latch_a_r});
          end
          ADDR_CRB: begin
            run_b_nxt = v[0];
            src_b_nxt = v[6:5];
            if (v[4]) count_b_nxt = signed'({{(CNT_W-LATCH_W){1'b0}}, latch_b_r});
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        count_a_nxt   = tick_cnt_a;
        count_b_nxt   = tick_cnt_b;
        flag_a_nxt    = flag_a_r | fired_a;
        flag_b_nxt    = flag_b_r | fired_b;
        res.nmi_pulse = fired_a | fired_b;
      end
      default: ;
    endcase

    res.video_bank_base = {~port_a_nxt[1:0], 14'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_a_r  <= PORT_RESET;
      port_b_r  <= PORT_RESET;
      latch_a_r <= '0;
      latch_b_r <= '0;
      count_a_r <= '0;
      count_b_r <= '0;
      run_a_r   <= 1'b0;
      run_b_r   <= 1'b0;
      src_a_r   <= SRC_A_CPU;
      src_b_r   <= SRC_B_CPU;
      ien_a_r   <= 1'b0;
      ien_b_r   <= 1'b0;
      flag_a_r  <= 1'b0;
      flag_b_r  <= 1'b0;
    end else if (fire) begin
      port_a_r  <= port_a_nxt;
      port_b_r  <= port_b_nxt;
      latch_a_r <= latch_a_nxt;
      latch_b_r <= latch_b_nxt;
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      run_a_r   <= run_a_nxt;
      run_b_r   <= run_b_nxt;
      src_a_r   <= src_a_nxt;
      src_b_r   <= src_b_nxt;
      ien_a_r   <= ien_a_nxt;
      ien_b_r   <= ien_b_nxt;
      flag_a_r  <= flag_a_nxt;
      flag_b_r  <= flag_b_nxt;
    end
  end

  // flags are sticky
  a_flag_a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flag_a_r |=> flag_a_r) else $error("timer A flag cleared");
  a_flag_b_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flag_b_r |=> flag_b_r) else $error("timer B flag cleared");
  a_nmi_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.nmi_pulse) |-> (is_tick && (ien_a_r || ien_b_r)))
    else $error("nmi outside an enabled tick");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(count_a_r) && $stable(count_b_r)))
    else $error("counter moved without a beat");

endmodule
`default_nettype wire

[rtl/dual_interval_timer_with_ports.sv]
// Top level: input register, timer core and result register.
// Each beat, a short subtract/compare on the state, passes the input register
// and then the result register; one beat per cycle unless out_ready stalls.
// An empty input register takes a new beat while a finished result waits.
// Reset: synchronous active low; ports read 0xff, other core state and valids clear.
`default_nettype none
module dual_interval_timer_with_ports (
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic        in_valid,
  output logic            in_ready,
  input  var logic [1:0]  in_req_type,
  input  var logic [3:0]  in_reg_addr,
  input  var logic [7:0]  in_write_data,
  input  var logic [7:0]  in_elapsed_cycles,
  output logic            out_valid,
  input  var logic        out_ready,
  output logic [7:0]      out_read_data,
  output logic            out_nmi_pulse,
  output logic [15:0]     out_video_bank_base
);
  import dit_pkg::*;

  logic  s1_valid_r;
  req_t  s1_req_r;
  logic  out_valid_r;
  res_t  out_res_r;
  res_t  core_res;
  logic  advance;
  logic  core_fire;
  logic  in_accept;

  assign advance   = !out_valid_r || out_ready;
  assign core_fire = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  dit_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (core_fire),
    .req   (s1_req_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (core_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (core_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= '{req_type: in_req_type, reg_addr: in_reg_addr,
                    write_data: in_write_data, elapsed_cycles: in_elapsed_cycles};
    end
    if (core_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_res_r.read_data;
  assign out_nmi_pulse       = out_res_r.nmi_pulse;
  assign out_video_bank_base = out_res_r.video_bank_base;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_req_r)))
    else $error("pending beat lost");
  a_out_from_core: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(core_fire))
    else $error("result without a core beat");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !core_fire)
    else $error("result overwritten");

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for dual_interval_timer_with_ports: predicted replies against the block.
class reply_tracker;
  dit_pkg::res_t pending_replies[$];
  int unsigned   mismatches;

  logic [7:0]    pa_data, pb_data;
  logic [15:0]   reload_a, reload_b;
  dit_pkg::cnt_t count_a, count_b;
  logic          run_a, run_b, src_a;
  logic [1:0]    src_b;
  logic          ien_a, ien_b, flag_a, flag_b;

  function new();
    pa_data    = dit_pkg::PORT_RESET;
    pb_data    = dit_pkg::PORT_RESET;
    reload_a   = '0;
    reload_b   = '0;
    count_a    = '0;
    count_b    = '0;
    run_a      = 1'b0;
    run_b      = 1'b0;
    src_a      = dit_pkg::SRC_A_CPU;
    src_b      = dit_pkg::SRC_B_CPU;
    ien_a      = 1'b0;
    ien_b      = 1'b0;
    flag_a     = 1'b0;
    flag_b     = 1'b0;
    mismatches = 0;
  endfunction

  // counts down by cycles; at zero or below the counter reloads
  function void count_down(input dit_pkg::cnt_t cnt_in, input logic [15:0] reload,
                           input logic [7:0] cycles, output dit_pkg::cnt_t cnt_out,
                           output logic expired);
    dit_pkg::cnt_t left;
    left    = cnt_in - dit_pkg::cnt_t'({10'b0, cycles});
    expired = (left <= 0);
    cnt_out = expired ? dit_pkg::cnt_t'({2'b00, reload}) : left;
  endfunction

  function void note_request(input logic [1:0] req, input logic [3:0] addr,
                             input logic [7:0] wdata, input logic [7:0] cycles);
    dit_pkg::res_t reply;
    logic          hit;
    reply = '0;
    case (req)
      dit_pkg::REQ_READ: begin
        case (addr)
          dit_pkg::ADDR_PORT_A: reply.read_data = pa_data;
          dit_pkg::ADDR_PORT_B: reply.read_data = pb_data;
          dit_pkg::ADDR_TA_LO:  reply.read_data = count_a[7:0];
          dit_pkg::ADDR_TA_HI:  reply.read_data = count_a[15:8];
          dit_pkg::ADDR_TB_LO:  reply.read_data = count_b[7:0];
          dit_pkg::ADDR_TB_HI:  reply.read_data = count_b[15:8];
          dit_pkg::ADDR_ICR:
            if (flag_a || flag_b) reply.read_data = {1'b1, 5'b0, flag_b, flag_a};
          default: ;
        endcase
      end
      dit_pkg::REQ_WRITE: begin
        case (addr)
          dit_pkg::ADDR_PORT_A: pa_data = wdata;
          dit_pkg::ADDR_PORT_B: pb_data = wdata;
          dit_pkg::ADDR_TA_LO:  reload_a[7:0] = wdata;
          dit_pkg::ADDR_TA_HI:  reload_a[15:8] = wdata;
          dit_pkg::ADDR_TB_LO:  reload_b[7:0] = wdata;
          dit_pkg::ADDR_TB_HI:  reload_b[15:8] = wdata;
          dit_pkg::ADDR_ICR: begin
            if (wdata[0]) ien_a = wdata[7];
            if (wdata[1]) ien_b = wdata[7];
          end
          dit_pkg::ADDR_CRA: begin
            run_a = wdata[0];
            src_a = wdata[5];
            if (wdata[4]) count_a = dit_pkg::cnt_t'({2'b00, reload_a});
          end
          dit_pkg::ADDR_CRB: begin
            run_b = wdata[0];
            src_b = wdata[6:5];
            if (wdata[4]) count_b = dit_pkg::cnt_t'({2'b00, reload_b});
          end
          default: ;
        endcase
      end
      dit_pkg::REQ_TICK: begin
        if (run_a && src_a == dit_pkg::SRC_A_CPU) begin
          count_down(count_a, reload_a, cycles, count_a, hit);
          if (hit && ien_a) begin
            flag_a          = 1'b1;
            reply.nmi_pulse = 1'b1;
          end
        end
        if (run_b && src_b == dit_pkg::SRC_B_CPU) begin
          count_down(count_b, reload_b, cycles, count_b, hit);
          if (hit && ien_b) begin
            flag_b          = 1'b1;
            reply.nmi_pulse = 1'b1;
          end
        end
      end
      default: ;
    endcase
    reply.video_bank_base = {~pa_data[1:0], 14'b0};
    pending_replies.push_back(reply);
  endfunction

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < 200) $display("mismatch on %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  task check_reply(input logic [7:0] rd, input logic nmi, input logic [15:0] vbb);
    dit_pkg::res_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch("unexpected beat", {rd, 7'b0, nmi, vbb}, '0);
      return;
    end
    want = pending_replies.pop_front();
    if (rd !== want.read_data)
      report_mismatch("read_data", 32'(rd), 32'(want.read_data));
    if (nmi !== want.nmi_pulse)
      report_mismatch("nmi_pulse", 32'(nmi), 32'(want.nmi_pulse));
    if (vbb !== want.video_bank_base)
      report_mismatch("video_bank_base", 32'(vbb), 32'(want.video_bank_base));
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dit_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [3:0] ADDR_GAP   = 4'h2;
  localparam logic [3:0] ADDR_SPARE = 4'h9;
  localparam int unsigned RANDOM_PER_PHASE = 382;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [3:0]  in_reg_addr;
  logic [7:0]  in_write_data;
  logic [7:0]  in_elapsed_cycles;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic        out_nmi_pulse;
  logic [15:0] out_video_bank_base;

  int unsigned send_idle;
  int unsigned recv_stall;
  reply_tracker sb;

  dual_interval_timer_with_ports i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_reg_addr         (in_reg_addr),
    .in_write_data       (in_write_data),
    .in_elapsed_cycles   (in_elapsed_cycles),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_nmi_pulse       (out_nmi_pulse),
    .out_video_bank_base (out_video_bank_base)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reply(out_read_data, out_nmi_pulse, out_video_bank_base);
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic drive_beat(input logic [1:0] req, input logic [3:0] addr,
                            input logic [7:0] wdata, input logic [7:0] cycles);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_reg_addr       <= addr;
    in_write_data     <= wdata;
    in_elapsed_cycles <= cycles;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, addr, wdata, cycles);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_replies.size() != 0) @(posedge clk);
  endtask

  // mostly timer set-up and short ticks so that expiries come often
  task automatic random_beat();
    int unsigned k;
    logic [1:0]  req;
    logic [3:0]  addr;
    logic [7:0]  wdata;
    logic [7:0]  cycles;
    k      = $urandom_range(99);
    addr   = 4'($urandom_range(15));
    wdata  = 8'($urandom_range(255));
    cycles = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    if (k < 4) begin
      req = REQ_UNUSED;
    end else if (k < 36) begin
      req = REQ_TICK;
    end else if (k < 64) begin
      req = REQ_READ;
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(4))
          0: addr = ADDR_TA_LO;
          1: addr = ADDR_TA_HI;
          2: addr = ADDR_TB_LO;
          3: addr = ADDR_TB_HI;
          default: addr = ADDR_ICR;
        endcase
      end
    end else begin
      req = REQ_WRITE;
      case ($urandom_range(9))
        0: addr = ADDR_PORT_A;
        1: addr = ADDR_PORT_B;
        2: ;
        3, 5: begin
          addr = (k[0]) ? ADDR_TA_LO : ADDR_TB_LO;
          if ($urandom_range(3) != 0) wdata = 8'($urandom_range(40));
        end
        4, 6: begin
          addr = (k[0]) ? ADDR_TA_HI : ADDR_TB_HI;
          if ($urandom_range(7) != 0) wdata = 8'h00;
        end
        7: addr = ADDR_ICR;
        8: begin
          addr     = ADDR_CRA;
          wdata[0] = ($urandom_range(99) < 85);
          wdata[5] = ($urandom_range(99) < 20);
        end
        default: begin
          addr     = ADDR_CRB;
          wdata[0] = ($urandom_range(99) < 85);
          if ($urandom_range(99) < 80) wdata[6:5] = SRC_B_CPU;
        end
      endcase
    end
    drive_beat(req, addr, wdata, cycles);
  endtask

  initial begin
    #(2_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    sb                = new();
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = REQ_READ;
    in_reg_addr       = '0;
    in_write_data     = '0;
    in_elapsed_cycles = '0;
    out_ready         = 1'b0;
    send_idle         = 0;
    recv_stall        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, unused slots, zero counter, expiry with and without enable
    drive_beat(REQ_READ,   ADDR_PORT_A, 8'h00, 8'h00);
    drive_beat(REQ_READ,   ADDR_ICR,    8'h00, 8'h00);
    drive_beat(REQ_READ,   ADDR_GAP,    8'h00, 8'h00);
    drive_beat(REQ_UNUSED, ADDR_CRB,    8'hff, 8'hff);
    drive_beat(REQ_WRITE,  ADDR_PORT_A, 8'h00, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_PORT_B, 8'ha5, 8'h00);
    drive_beat(REQ_READ,   ADDR_PORT_B, 8'h00, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_SPARE,  8'hff, 8'h00);
    drive_beat(REQ_READ,   ADDR_SPARE,  8'h00, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_CRA,    8'h01, 8'h00);
    drive_beat(REQ_TICK,   4'h0,        8'h00, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_TA_LO,  8'hff, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_TA_HI,  8'hff, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_CRA,    8'h11, 8'h00);
    drive_beat(REQ_READ,   ADDR_TA_HI,  8'h00, 8'h00);
    drive_beat(REQ_TICK,   4'h0,        8'h00, 8'hff);
    drive_beat(REQ_READ,   ADDR_TA_LO,  8'h00, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_ICR,    8'h83, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_TA_HI,  8'h00, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_CRA,    8'h11, 8'h00);
    drive_beat(REQ_TICK,   4'h0,        8'h00, 8'hff);
    drive_beat(REQ_WRITE,  ADDR_CRB,    8'h31, 8'h00);
    drive_beat(REQ_TICK,   4'h0,        8'h00, 8'h01);
    drive_beat(REQ_WRITE,  ADDR_CRB,    8'h11, 8'h00);
    drive_beat(REQ_TICK,   4'h0,        8'h00, 8'h00);
    drive_beat(REQ_READ,   ADDR_ICR,    8'h00, 8'h00);
    drive_beat(REQ_WRITE,  ADDR_PORT_A, 8'h02, 8'h00);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 52; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 52; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_beat();
      wait_drained();
    end

    recv_stall = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
